>>> src/csq_pkg.sv
// ============================================================================
// csq_pkg: shared definitions for the counting semaphore wait queue
// Widths, queue sizing, operation and outcome codes, register map and the
// circular index helper.
// ============================================================================
package csq_pkg;

    // queue sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;

    // item field widths
    localparam int OP_BITS       = 2;
    localparam int ID_FIELD_BITS = 8;
    localparam int OUTCOME_BITS  = 3;
    localparam int COUNT_BITS    = 16;

    // stored id width: the id field is eight bits, masked to ID_BITS
    localparam int STORE_BITS = (ID_BITS < ID_FIELD_BITS) ? ID_BITS : ID_FIELD_BITS;

    // pointer and occupancy widths
    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_BITS = CNT_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration port
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam logic REG_INITIAL_COUNT = 1'b0;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_WAIT   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_POST   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

    typedef enum logic [OUTCOME_BITS-1:0] {
        OUT_GRANTED  = 3'd0,
        OUT_BLOCKED  = 3'd1,
        OUT_RELEASED = 3'd2,
        OUT_COUNTED  = 3'd3,
        OUT_IGNORED  = 3'd4,
        OUT_DELETED  = 3'd5,
        OUT_FULL     = 3'd6
    } outcome_t;

    // (base + off) modulo QUEUE_DEPTH, valid for base + off < 2 * QUEUE_DEPTH
    function automatic logic [PTR_BITS-1:0] wrap_add(
        input logic [PTR_BITS-1:0] base,
        input logic [CNT_BITS-1:0] off
    );
        logic [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(base) + SUM_BITS'(off);
        if (sum >= SUM_BITS'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_BITS'(QUEUE_DEPTH);
        end
        return sum[PTR_BITS-1:0];
    endfunction

endpackage

>>> src/csq_if.sv
// ============================================================================
// csq_if: request and response channels
// Valid/ready channels carrying semaphore requests and their result items.
// ============================================================================

// request channel: one semaphore operation per item
interface csq_req_if;
    logic                               valid;
    logic                               ready;
    logic [csq_pkg::OP_BITS-1:0]        operation;
    logic [csq_pkg::ID_FIELD_BITS-1:0]  caller_id;
    logic                               from_handler;

    modport source (output valid, output operation, output caller_id,
                    output from_handler, input ready);
    modport sink   (input valid, input operation, input caller_id,
                    input from_handler, output ready);
endinterface

// response channel: one result item per handshake
interface csq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [csq_pkg::OUTCOME_BITS-1:0]   outcome;
    logic [csq_pkg::ID_FIELD_BITS-1:0]  released_id;
    logic                               preempt;
    logic                               last;

    modport source (output valid, output outcome, output released_id,
                    output preempt, output last, input ready);
    modport sink   (input valid, input outcome, input released_id,
                    input preempt, input last, output ready);
endinterface

>>> src/counting_semaphore_wait_queue_core.sv
// ============================================================================
// counting_semaphore_wait_queue_core: semaphore with FIFO wait queue
// Result path: single-result items appear in the output register in the cycle
//   after accept; a releasing post passes the registered waiter memory read
//   first. Throughput: one item per cycle for grant/block/count/ignore and
//   one delete release per cycle via the memory read port, while the response
//   is taken; a post or delete with waiters holds off new requests until done.
// Reset: asynchronous; count 0, queue empty; waiter memory is not cleared.
// ============================================================================
module counting_semaphore_wait_queue_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csq_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [csq_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [csq_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    csq_req_if.sink                             req,
    csq_rsp_if.source                           rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POST,
        S_DEL
    } state_t;

    state_t                               state_reg, state_next;
    logic [csq_pkg::COUNT_BITS-1:0]       initial_count_reg;
    logic [csq_pkg::COUNT_BITS-1:0]       grant_count_reg, grant_count_next;
    logic [csq_pkg::PTR_BITS-1:0]         queue_head_reg, queue_head_next;
    logic [csq_pkg::CNT_BITS-1:0]         waiter_total_reg, waiter_total_next;
    logic [csq_pkg::PTR_BITS-1:0]         del_idx_reg, del_idx_next;

    logic                                 out_valid_reg, out_valid_next;
    csq_pkg::outcome_t                    out_outcome_reg, out_outcome_next;
    logic [csq_pkg::ID_FIELD_BITS-1:0]    out_id_reg, out_id_next;
    logic                                 out_preempt_reg, out_preempt_next;
    logic                                 out_last_reg, out_last_next;

    // waiter memory, one write and one registered read port
    logic [csq_pkg::STORE_BITS-1:0]       waiter_mem [csq_pkg::QUEUE_DEPTH];
    logic [csq_pkg::STORE_BITS-1:0]       rdata_reg;
    logic                                 mem_we, mem_re;
    logic [csq_pkg::PTR_BITS-1:0]         mem_waddr, mem_raddr;
    logic [csq_pkg::STORE_BITS-1:0]       mem_wdata;

    logic                                 cfg_hit, cfg_write, accept, out_free;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[csq_pkg::APB_ADDR_BITS-1:2] == csq_pkg::REG_INITIAL_COUNT);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? csq_pkg::APB_DATA_BITS'(initial_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            initial_count_reg <= pwdata[csq_pkg::COUNT_BITS-1:0];
        end
    end

    // handshakes
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.outcome     = out_outcome_reg;
    assign rsp.released_id = out_id_reg;
    assign rsp.preempt     = out_preempt_reg;
    assign rsp.last        = out_last_reg;

    // operation sequencing; writes and reads of one entry never share a cycle
    always_comb
    begin
        state_next        = state_reg;
        grant_count_next  = grant_count_reg;
        queue_head_next   = queue_head_reg;
        waiter_total_next = waiter_total_reg;
        del_idx_next      = del_idx_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_outcome_next  = out_outcome_reg;
        out_id_next       = out_id_reg;
        out_preempt_next  = out_preempt_reg;
        out_last_next     = out_last_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = csq_pkg::wrap_add(queue_head_reg, waiter_total_reg);
        mem_wdata         = req.caller_id[csq_pkg::STORE_BITS-1:0];
        mem_raddr         = queue_head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next   = 1'b1;
                    out_id_next      = '0;
                    out_preempt_next = 1'b0;
                    out_last_next    = 1'b1;
                    out_outcome_next = csq_pkg::OUT_IGNORED;
                    if (!req.from_handler)
                    begin
                        unique case (req.operation)
                            csq_pkg::OP_WAIT:
                            begin
                                if (grant_count_reg != '0)
                                begin
                                    grant_count_next = grant_count_reg - 1'b1;
                                    out_outcome_next = csq_pkg::OUT_GRANTED;
                                end
                                else if (waiter_total_reg <
                                         csq_pkg::CNT_BITS'(csq_pkg::QUEUE_DEPTH))
                                begin
                                    mem_we            = 1'b1;
                                    waiter_total_next = waiter_total_reg + 1'b1;
                                    out_outcome_next  = csq_pkg::OUT_BLOCKED;
                                    out_preempt_next  = 1'b1;
                                end
                                else
                                begin
                                    out_outcome_next = csq_pkg::OUT_FULL;
                                end
                            end
                            csq_pkg::OP_POST:
                            begin
                                if (waiter_total_reg != '0)
                                begin
                                    // release comes out after the memory read
                                    out_valid_next    = 1'b0;
                                    mem_re            = 1'b1;
                                    queue_head_next   = csq_pkg::wrap_add(
                                        queue_head_reg, csq_pkg::CNT_BITS'(1));
                                    waiter_total_next = waiter_total_reg - 1'b1;
                                    state_next        = S_POST;
                                end
                                else
                                begin
                                    if (grant_count_reg != csq_pkg::COUNT_MAX)
                                    begin
                                        grant_count_next = grant_count_reg + 1'b1;
                                    end
                                    out_outcome_next = csq_pkg::OUT_COUNTED;
                                end
                            end
                            csq_pkg::OP_DELETE:
                            begin
                                if (waiter_total_reg != '0)
                                begin
                                    // walk from the newest waiter back
                                    out_valid_next = 1'b0;
                                    mem_re         = 1'b1;
                                    mem_raddr      = csq_pkg::wrap_add(queue_head_reg,
                                                     waiter_total_reg - 1'b1);
                                    del_idx_next   = csq_pkg::PTR_BITS'(
                                                     waiter_total_reg - 1'b1);
                                    state_next     = S_DEL;
                                end
                                else
                                begin
                                    out_outcome_next  = csq_pkg::OUT_DELETED;
                                    queue_head_next   = '0;
                                    grant_count_next  = initial_count_reg;
                                end
                            end
                            default:
                            begin
                                out_outcome_next = csq_pkg::OUT_IGNORED;
                            end
                        endcase
                    end
                end
            end
            S_POST:
            begin
                // output register was freed at accept
                out_valid_next   = 1'b1;
                out_outcome_next = csq_pkg::OUT_RELEASED;
                out_id_next      = csq_pkg::ID_FIELD_BITS'(rdata_reg);
                out_preempt_next = 1'b1;
                out_last_next    = 1'b1;
                state_next       = S_IDLE;
            end
            S_DEL:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_outcome_next = csq_pkg::OUT_RELEASED;
                    out_id_next      = csq_pkg::ID_FIELD_BITS'(rdata_reg);
                    out_preempt_next = 1'b0;
                    out_last_next    = (del_idx_reg == '0);
                    if (del_idx_reg == '0)
                    begin
                        queue_head_next   = '0;
                        waiter_total_next = '0;
                        grant_count_next  = initial_count_reg;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        del_idx_next = del_idx_reg - 1'b1;
                        mem_re       = 1'b1;
                        mem_raddr    = csq_pkg::wrap_add(queue_head_reg,
                                       csq_pkg::CNT_BITS'(del_idx_reg - 1'b1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            grant_count_reg  <= '0;
            queue_head_reg   <= '0;
            waiter_total_reg <= '0;
            del_idx_reg      <= '0;
            out_valid_reg    <= 1'b0;
            out_outcome_reg  <= csq_pkg::OUT_GRANTED;
            out_id_reg       <= '0;
            out_preempt_reg  <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            grant_count_reg  <= grant_count_next;
            queue_head_reg   <= queue_head_next;
            waiter_total_reg <= waiter_total_next;
            del_idx_reg      <= del_idx_next;
            out_valid_reg    <= out_valid_next;
            out_outcome_reg  <= out_outcome_next;
            out_id_reg       <= out_id_next;
            out_preempt_reg  <= out_preempt_next;
            out_last_reg     <= out_last_next;
        end
    end

    // waiter memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            waiter_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= waiter_mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    // occupancy never exceeds the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        waiter_total_reg <= csq_pkg::CNT_BITS'(csq_pkg::QUEUE_DEPTH))
        else $error("waiter count above queue depth");

    // every queue write reports a blocked caller
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> out_valid_reg && (out_outcome_reg == csq_pkg::OUT_BLOCKED))
        else $error("queue write without blocked result");

    // the pending release always finds the output register empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POST) |-> !out_valid_reg)
        else $error("post release would overwrite a pending result");

    // the final delete release leaves the queue empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL) && out_free && (del_idx_reg == '0) |=>
        (waiter_total_reg == '0) && (queue_head_reg == '0) && out_last_reg)
        else $error("delete did not empty the queue");
`endif

endmodule
